// ===== rtl/rgsp_pkg.sv =====
// Shared types, codes and constant tables of the radix group symbol packer.
package rgsp_pkg;

  localparam int unsigned MaxLowBits = 8;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    FamBinary = 2'd0,
    FamTrit   = 2'd1,
    FamQuint  = 2'd2
  } family_e;

  // Register index, taken from paddr[2].
  localparam logic RegFamily  = 1'b0;
  localparam logic RegLowBits = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       error;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  // Place value of the next symbol in a radix group that already holds fill symbols.
  function automatic logic [7:0] radix_weight(input logic [1:0] fam, input logic [2:0] fill);
    logic [7:0] w;
    w = 8'd1;
    if (fam == FamTrit) begin
      unique case (fill)
        3'd0:    w = 8'd1;
        3'd1:    w = 8'd3;
        3'd2:    w = 8'd9;
        3'd3:    w = 8'd27;
        3'd4:    w = 8'd81;
        default: w = 8'd0;
      endcase
    end else begin
      unique case (fill)
        3'd0:    w = 8'd1;
        3'd1:    w = 8'd5;
        3'd2:    w = 8'd25;
        default: w = 8'd0;
      endcase
    end
    return w;
  endfunction

  // Bits written for a short final group: ceil(8k/5) for trits, ceil(7k/3) for quints.
  function automatic logic [3:0] tail_bits(input logic [1:0] fam, input logic [2:0] fill);
    logic [3:0] n;
    n = 4'd0;
    if (fam == FamTrit) begin
      unique case (fill)
        3'd1:    n = 4'd2;
        3'd2:    n = 4'd4;
        3'd3:    n = 4'd5;
        3'd4:    n = 4'd7;
        default: n = 4'd0;
      endcase
    end else begin
      unique case (fill)
        3'd1:    n = 4'd3;
        3'd2:    n = 4'd5;
        default: n = 4'd0;
      endcase
    end
    return n;
  endfunction

endpackage

// ===== rtl/radix_group_symbol_packer.sv =====
// Radix group symbol packer: packs binary, trit or quint symbols LSB-first into bytes.
//
// Usage: symbols enter on the slave stream (s_axis_tdata = symbol, s_axis_tlast marks the
// final symbol of a sequence). Packed bytes leave on the master stream: m_axis_tdata is
// the byte, m_axis_tuser carries byte_valid and error, m_axis_tlast marks the final word
// of a sequence. A word with byte_valid low is an end marker (error low) or the single
// error word (error high); after an error the rest of the sequence is dropped.
// The APB port holds family (0x0) and low_bits (0x4); writing either clears the
// sequence state, so write only while the block is idle.
// A result word is written into the result queue when its symbol is accepted.
// Throughput: one symbol per cycle while the queue has room; the packing logic between
// the input handshake and the four-entry result queue is a single pass. A symbol can
// yield two words (a full byte plus the flushed tail), which the queue drains at one word
// per cycle while the receiver is ready. When the receiver stalls, words collect in the
// queue and s_axis_tready drops once all four entries are in use. Reset clears the
// registers, the sequence state and the queue.
module radix_group_symbol_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] symbol
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
  output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] error
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rgsp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [1:0]  family_q;
  logic [3:0]  low_bits_q;
  logic [14:0] pending_bits_q, pending_bits_d;
  logic [3:0]  pending_count_q, pending_count_d;
  logic [7:0]  group_value_q, group_value_d;
  logic [2:0]  group_fill_q, group_fill_d;
  logic        discarding_q, discarding_d;

  entry_t            queue_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              sub_q;

  logic        cfg_write;
  logic        in_fire, out_fire, push_q_en, pop_entry;
  logic        cfg_ok, sym_bad;
  logic [10:0] product;
  logic [7:0]  gv_sum;
  logic [2:0]  fill_inc;
  logic        group_done;
  logic        push_en;
  logic [7:0]  push_val;
  logic [3:0]  push_n;
  logic [8:0]  push_mask;
  logic [14:0] combined;
  logic [4:0]  count_sum;
  logic        byte_out;
  logic [1:0]  n_res;
  result_t     res_a, res_b;
  entry_t      new_entry;
  result_t     head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == RegLowBits) ? {28'd0, low_bits_q} : {30'd0, family_q};

  assign s_axis_tready = (count_q != CntW'(QueueDepth));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cfg_ok = (family_q == FamBinary || family_q == FamTrit || family_q == FamQuint) &&
             (low_bits_q <= 4'(MaxLowBits)) &&
             (family_q == FamBinary || low_bits_q == 4'd0);
    if (family_q == FamBinary) begin
      sym_bad = (s_axis_tdata >> low_bits_q) != 16'd0;
    end else if (family_q == FamTrit) begin
      sym_bad = s_axis_tdata > 16'd2;
    end else begin
      sym_bad = s_axis_tdata > 16'd4;
    end
    sym_bad = sym_bad || !cfg_ok;
  end

  // Radix group accumulation: one small constant-weight multiply and an 8-bit add.
  assign product  = s_axis_tdata[2:0] * radix_weight(family_q, group_fill_q);
  assign gv_sum   = group_value_q + product[7:0];
  assign fill_inc = group_fill_q + 3'd1;
  assign group_done = (family_q == FamTrit) ? (fill_inc >= 3'd5) : (fill_inc >= 3'd3);

  always_comb begin
    group_value_d = group_value_q;
    group_fill_d  = group_fill_q;
    push_en       = 1'b0;
    push_val      = 8'd0;
    push_n        = 4'd0;
    if (family_q == FamBinary) begin
      push_en  = 1'b1;
      push_val = s_axis_tdata[7:0];
      push_n   = low_bits_q;
    end else begin
      group_value_d = gv_sum;
      group_fill_d  = fill_inc;
      if (group_done || s_axis_tlast) begin
        push_en       = 1'b1;
        push_val      = gv_sum;
        push_n        = group_done ? ((family_q == FamTrit) ? 4'd8 : 4'd7)
                                   : tail_bits(family_q, fill_inc);
        group_value_d = 8'd0;
        group_fill_d  = 3'd0;
      end
    end
  end

  // Bit appender: at most eight new bits, at most one full byte out.
  always_comb begin
    push_mask = (9'd1 << push_n) - 9'd1;
    combined  = pending_bits_q | ({7'd0, push_val & push_mask[7:0]} << pending_count_q);
    count_sum = {1'b0, pending_count_q} + (push_en ? {1'b0, push_n} : 5'd0);
    if (!push_en) begin
      combined = pending_bits_q;
    end
    byte_out = count_sum >= 5'd8;
  end

  // Next sequence state and the result words of this symbol.
  always_comb begin
    pending_bits_d  = pending_bits_q;
    pending_count_d = pending_count_q;
    discarding_d    = discarding_q;
    n_res           = 2'd0;
    res_a           = '0;
    res_b           = '0;
    if (discarding_q) begin
      if (s_axis_tlast) begin
        discarding_d = 1'b0;
      end
    end else if (sym_bad) begin
      n_res             = 2'd1;
      res_a.error       = 1'b1;
      res_a.last_result = 1'b1;
      pending_bits_d    = '0;
      pending_count_d   = '0;
      discarding_d      = !s_axis_tlast;
    end else begin
      if (byte_out) begin
        pending_bits_d  = combined >> 8;
        pending_count_d = 4'(count_sum - 5'd8);
      end else begin
        pending_bits_d  = combined;
        pending_count_d = count_sum[3:0];
      end
      if (byte_out) begin
        n_res            = 2'd1;
        res_a.data_byte  = combined[7:0];
        res_a.byte_valid = 1'b1;
      end
      if (s_axis_tlast) begin
        if (pending_count_d != 4'd0) begin
          if (byte_out) begin
            n_res             = 2'd2;
            res_b.data_byte   = pending_bits_d[7:0];
            res_b.byte_valid  = 1'b1;
            res_b.last_result = 1'b1;
          end else begin
            n_res             = 2'd1;
            res_a.data_byte   = pending_bits_d[7:0];
            res_a.byte_valid  = 1'b1;
            res_a.last_result = 1'b1;
          end
        end else begin
          // An already emitted byte takes the end mark, else an empty end marker goes out.
          n_res             = 2'd1;
          res_a.last_result = 1'b1;
        end
        pending_bits_d  = '0;
        pending_count_d = '0;
      end
    end
  end

  assign new_entry = '{two: (n_res == 2'd2), r0: res_a, r1: res_b};
  assign push_q_en = in_fire && (n_res != 2'd0);

  assign head          = sub_q ? queue_q[rd_ptr_q].r1 : queue_q[rd_ptr_q].r0;
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = head.data_byte;
  assign m_axis_tuser  = {head.error, head.byte_valid};
  assign m_axis_tlast  = head.last_result;
  assign pop_entry     = out_fire && (sub_q || !queue_q[rd_ptr_q].two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q        <= '0;
      low_bits_q      <= '0;
      pending_bits_q  <= '0;
      pending_count_q <= '0;
      group_value_q   <= '0;
      group_fill_q    <= '0;
      discarding_q    <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == RegFamily) begin
        family_q <= pwdata[1:0];
      end else begin
        low_bits_q <= pwdata[3:0];
      end
      pending_bits_q  <= '0;
      pending_count_q <= '0;
      group_value_q   <= '0;
      group_fill_q    <= '0;
      discarding_q    <= 1'b0;
    end else if (in_fire) begin
      pending_bits_q  <= pending_bits_d;
      pending_count_q <= pending_count_d;
      discarding_q    <= discarding_d;
      if (discarding_q || sym_bad) begin
        group_value_q <= '0;
        group_fill_q  <= '0;
      end else begin
        group_value_q <= s_axis_tlast ? 8'd0 : group_value_d;
        group_fill_q  <= s_axis_tlast ? 3'd0 : group_fill_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sub_q    <= 1'b0;
    end else begin
      if (push_q_en) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (out_fire) begin
        sub_q <= !pop_entry;
      end
      if (pop_entry) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_q_en) - CntW'(pop_entry);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_q_en) begin
      queue_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule
